FILE: rtl/hsms_pkg.sv
// Shared types, codes and the half-step phase table of the stepper sequencer.
package hsms_pkg;

  localparam int StepCountWidth = 24;
  localparam int PeriodWidth    = 16;
  localparam int PosWidth       = 32;

  localparam logic [PeriodWidth-1:0] ResetPeriodUs = 16'd100;

  localparam logic [1:0] FN_TICK   = 2'd0;
  localparam logic [1:0] FN_START  = 2'd1;
  localparam logic [1:0] FN_SETPOS = 2'd2;
  localparam logic [1:0] FN_STATUS = 2'd3;

  // One coil bit per winding, eight half-step phases.
  localparam logic [3:0] PHASE_PATTERN [8] = '{
    4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9
  };

  typedef struct packed {
    logic [1:0]                func;
    logic [StepCountWidth-1:0] step_count;
    logic                      direction;
    logic [PeriodWidth-1:0]    period_us;
    logic signed [PosWidth-1:0] new_position;
  } item_t;

  typedef struct packed {
    logic [3:0]                 coil_pattern;
    logic signed [PosWidth-1:0] position;
    logic                       moving;
  } status_t;

endpackage

FILE: rtl/hsms_if.sv
// Valid/ready channels for sequencer commands and status beats.
interface hsms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [hsms_pkg::StepCountWidth-1:0] step_count;
  logic        direction;
  logic [15:0] period_us;
  logic signed [31:0] new_position;

  modport source (output valid, func, step_count, direction, period_us, new_position,
                  input ready);
  modport sink   (input valid, func, step_count, direction, period_us, new_position,
                  output ready);
endinterface

interface hsms_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  coil_pattern;
  logic signed [31:0] position;
  logic        moving;

  modport source (output valid, coil_pattern, position, moving, input ready);
  modport sink   (input valid, coil_pattern, position, moving, output ready);
endinterface

FILE: rtl/half_step_motor_sequencer.sv
// Half-step sequencer for a four-coil unipolar stepper, top level.
// Every command beat on in_ch (tick, start move, set position, read status) yields exactly one
// status beat on out_ch carrying the coil bits, the position and the moving flag as they stand
// after that command. A command is taken every cycle: the move state
// updates at the accepting edge and the status lands in a single output register, which is
// refilled in the same cycle it drains, so in_ch.ready only drops while a status beat waits
// and out_ch.ready is low. cfg_wdata sets the minimum step period in ticks (reset 100) and
// should be written while no beat is outstanding.
module half_step_motor_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  hsms_in_if.sink              in_ch,
  hsms_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);

  logic [hsms_pkg::PeriodWidth-1:0] min_period_r;
  logic                             out_valid_r;
  hsms_pkg::status_t                status_r;
  hsms_pkg::status_t                status_nxt;
  hsms_pkg::item_t                  item;
  logic                             accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign item.func         = in_ch.func;
  assign item.step_count   = in_ch.step_count;
  assign item.direction    = in_ch.direction;
  assign item.period_us    = in_ch.period_us;
  assign item.new_position = in_ch.new_position;

  hsms_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .item       (item),
    .min_period (min_period_r),
    .status_nxt (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= hsms_pkg::ResetPeriodUs;
    end else if (cfg_we) begin
      min_period_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the status beat until taken
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.coil_pattern = status_r.coil_pattern;
  assign out_ch.position     = status_r.position;
  assign out_ch.moving       = status_r.moving;

endmodule

FILE: rtl/hsms_core.sv
// Move state of the sequencer: tick counter, step counter, phase and position.
module hsms_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  hsms_pkg::item_t                     item,
  input  logic [hsms_pkg::PeriodWidth-1:0]    min_period,
  output hsms_pkg::status_t                   status_nxt
);

  logic [2:0]                             phase_r, phase_nxt;
  logic signed [hsms_pkg::PosWidth-1:0]   pos_r, pos_nxt;
  logic [hsms_pkg::StepCountWidth-1:0]    done_r, done_nxt;
  logic [hsms_pkg::StepCountWidth-1:0]    target_r, target_nxt;
  logic                                   dir_r, dir_nxt;
  logic [hsms_pkg::PeriodWidth-1:0]       period_r, period_nxt;
  logic [hsms_pkg::PeriodWidth-1:0]       tick_r, tick_nxt;
  logic                                   running_r, running_nxt;
  logic [3:0]                             coil_r, coil_nxt;

  logic [hsms_pkg::PeriodWidth:0]         tick_inc;
  logic [hsms_pkg::PeriodWidth-1:0]       period_clamped;

  assign tick_inc       = {1'b0, tick_r} + 17'd1;
  assign period_clamped = (item.period_us < min_period) ? min_period : item.period_us;

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    done_nxt    = done_r;
    target_nxt  = target_r;
    dir_nxt     = dir_r;
    period_nxt  = period_r;
    tick_nxt    = tick_r;
    running_nxt = running_r;
    coil_nxt    = coil_r;
    if (accept) begin
      unique case (item.func)
        hsms_pkg::FN_TICK: begin
          if (running_r) begin
            if (tick_inc >= {1'b0, period_r}) begin
              tick_nxt = '0;
              if (done_r >= target_r) begin
                // move complete: drop all coils
                running_nxt = 1'b0;
                coil_nxt    = 4'h0;
              end else begin
                coil_nxt = hsms_pkg::PHASE_PATTERN[phase_r];
                if (dir_r) begin
                  phase_nxt = phase_r + 3'd1;
                  pos_nxt   = pos_r + 32'sd1;
                end else begin
                  phase_nxt = phase_r - 3'd1;
                  pos_nxt   = pos_r - 32'sd1;
                end
                done_nxt = done_r + {{(hsms_pkg::StepCountWidth-1){1'b0}}, 1'b1};
              end
            end else begin
              tick_nxt = tick_inc[hsms_pkg::PeriodWidth-1:0];
            end
          end
        end
        hsms_pkg::FN_START: begin
          // restart at once; phase and coil drive carry over
          period_nxt  = period_clamped;
          dir_nxt     = item.direction;
          target_nxt  = item.step_count[hsms_pkg::StepCountWidth-1:0];
          done_nxt    = '0;
          tick_nxt    = '0;
          running_nxt = 1'b1;
        end
        hsms_pkg::FN_SETPOS: begin
          pos_nxt = item.new_position;
        end
        hsms_pkg::FN_STATUS: begin
          running_nxt = running_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      pos_r     <= '0;
      done_r    <= '0;
      target_r  <= '0;
      dir_r     <= 1'b0;
      period_r  <= hsms_pkg::ResetPeriodUs;
      tick_r    <= '0;
      running_r <= 1'b0;
      coil_r    <= 4'h0;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      done_r    <= done_nxt;
      target_r  <= target_nxt;
      dir_r     <= dir_nxt;
      period_r  <= period_nxt;
      tick_r    <= tick_nxt;
      running_r <= running_nxt;
      coil_r    <= coil_nxt;
    end
  end

  assign status_nxt.coil_pattern = coil_nxt;
  assign status_nxt.position     = pos_nxt;
  assign status_nxt.moving       = running_nxt;

endmodule
